// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/sfmn_pkg.sv =====
// Package: sizes, command and status types of the missing-number finder.
package sfmn_pkg;

   localparam int MAX_ITEMS  = 64;
   localparam int VALUE_BITS = 16;
   localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
   localparam int IDX_BITS   = $clog2(MAX_ITEMS);
   localparam int MISS_BITS  = VALUE_BITS + 1;
   // wide enough for counts, values plus one and index sums
   localparam int CMP_BITS   = ((CNT_BITS > MISS_BITS) ? CNT_BITS : MISS_BITS) + 1;

   typedef struct packed {
      logic load;
      logic rd_i;
      logic ld_i;
      logic cmp;
      logic wr_i;
      logic sc_rd;
      logic sc_first;
      logic sc_cmp;
      logic push;
   } sfmn_cmd_type;

   typedef struct packed {
      logic empty;
      logic j_more;
      logic i_more;
      logic n_one;
      logic sc_done;
      logic out_free;
   } sfmn_status_type;

endpackage

// ===== rtl/core/sfmn_req_if.sv =====
// Input channel: one value beat with its last flag.
interface sfmn_req_if import sfmn_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic                  last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

// ===== rtl/core/sfmn_rsp_if.sv =====
// Result channel: the missing number and the overflow flag.
interface sfmn_rsp_if import sfmn_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MISS_BITS-1:0] missing;
   logic                 overflowed;

   modport source (output valid, output missing, output overflowed, input ready);
   modport sink (input valid, input missing, input overflowed, output ready);
endinterface

// ===== rtl/core/sfmn_ctrl.sv =====
// Controller: sequences load, exchange sort, scan and result push.
module sfmn_ctrl import sfmn_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_last,
   output logic            req_ready,
   input  sfmn_status_type status,
   output sfmn_cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_LOAD     = 9'b0_0000_0001,
      ST_RD_I     = 9'b0_0000_0010,
      ST_LD_I     = 9'b0_0000_0100,
      ST_CMP      = 9'b0_0000_1000,
      ST_WR_I     = 9'b0_0001_0000,
      ST_SC_RD    = 9'b0_0010_0000,
      ST_SC_FIRST = 9'b0_0100_0000,
      ST_SC_CMP   = 9'b0_1000_0000,
      ST_PUSH     = 9'b1_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid && req_last) begin
               // a lone value needs no sort
               state_in = status.empty ? ST_SC_RD : ST_RD_I;
            end
         end
         ST_RD_I: begin
            cmd.rd_i = 1'b1;
            state_in = ST_LD_I;
         end
         ST_LD_I: begin
            cmd.ld_i = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp = 1'b1;
            if (!status.j_more) begin
               state_in = ST_WR_I;
            end
         end
         ST_WR_I: begin
            cmd.wr_i = 1'b1;
            state_in = status.i_more ? ST_LD_I : ST_SC_RD;
         end
         ST_SC_RD: begin
            cmd.sc_rd = 1'b1;
            state_in  = ST_SC_FIRST;
         end
         ST_SC_FIRST: begin
            cmd.sc_first = 1'b1;
            state_in     = status.n_one ? ST_PUSH : ST_SC_CMP;
         end
         ST_SC_CMP: begin
            cmd.sc_cmp = 1'b1;
            if (status.sc_done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

// ===== rtl/core/sfmn_datapath.sv =====
// Datapath: value store, sort and scan registers, output register.
module sfmn_datapath import sfmn_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  sfmn_cmd_type          cmd,
   output sfmn_status_type       status,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [MISS_BITS-1:0]  rsp_missing,
   output logic                  rsp_overflowed
);

   logic [VALUE_BITS-1:0] mem [MAX_ITEMS];
   logic [VALUE_BITS-1:0] rd_ff;
   logic [IDX_BITS-1:0]   rd_addr;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [VALUE_BITS-1:0] wr_data;

   logic [VALUE_BITS-1:0] cur_ff, cur_in;
   logic [VALUE_BITS-1:0] prev_ff, prev_in;
   logic [MISS_BITS-1:0]  res_ff, res_in;
   logic [IDX_BITS-1:0]   i_ff, i_in;
   logic [IDX_BITS-1:0]   j_ff, j_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic                  out_valid_ff, out_valid_in;
   logic [MISS_BITS-1:0]  out_miss_ff, out_miss_in;
   logic                  out_ovf_ff, out_ovf_in;

   logic                  full;
   logic                  swap;
   logic                  hit;
   logic                  sc_more;
   logic [IDX_BITS-1:0]   i_plus;
   logic [IDX_BITS-1:0]   j_plus;
   logic [CMP_BITS-1:0]   n_wide;
   logic [CMP_BITS-1:0]   hi_wide;
   logic [CMP_BITS-1:0]   lo_wide;
   logic [MISS_BITS-1:0]  final_val;
   logic [MISS_BITS-1:0]  lo_plus;

   assign full      = (count_ff == CNT_BITS'(MAX_ITEMS));
   assign swap      = (cur_ff > rd_ff);
   assign i_plus    = i_ff + IDX_BITS'(1);
   assign j_plus    = j_ff + IDX_BITS'(1);
   assign n_wide    = CMP_BITS'(count_ff);
   assign hi_wide   = CMP_BITS'(rd_ff);
   assign lo_wide   = CMP_BITS'(prev_ff);
   assign hit       = (rd_ff == prev_ff) || (hi_wide > lo_wide + CMP_BITS'(1));
   assign sc_more   = (CMP_BITS'(i_ff) + CMP_BITS'(1)) < n_wide;
   assign lo_plus   = MISS_BITS'(lo_wide + CMP_BITS'(1));
   // no gap found: zero if the top value equals the count, else the count
   assign final_val = (hi_wide == n_wide) ? '0 : MISS_BITS'(n_wide);

   always_comb begin
      status          = '0;
      status.empty    = (count_ff == '0);
      status.j_more   = (CMP_BITS'(j_ff) + CMP_BITS'(1)) < n_wide;
      status.i_more   = (CMP_BITS'(i_ff) + CMP_BITS'(2)) < n_wide;
      status.n_one    = (count_ff == CNT_BITS'(1));
      status.sc_done  = hit || !sc_more;
      status.out_free = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      rd_addr = i_ff;
      if (cmd.ld_i || cmd.wr_i || cmd.sc_cmp) begin
         rd_addr = i_plus;
      end else if (cmd.cmp) begin
         rd_addr = j_plus;
      end else if (cmd.sc_rd) begin
         rd_addr = '0;
      end else if (cmd.sc_first) begin
         rd_addr = IDX_BITS'(1);
      end else if (cmd.rd_i) begin
         rd_addr = i_ff;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = i_ff;
      wr_data = cur_ff;
      if (cmd.load && !full) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IDX_BITS-1:0];
         wr_data = req_value;
      end else if (cmd.cmp && swap) begin
         wr_en   = 1'b1;
         wr_addr = j_ff;
      end else if (cmd.wr_i) begin
         wr_en   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      res_in       = res_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      out_valid_in = out_valid_ff;
      out_miss_in  = out_miss_ff;
      out_ovf_in   = out_ovf_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.load) begin
         i_in = '0;
         // drop the beat when the store is full
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_BITS'(1);
         end
      end

      if (cmd.ld_i) begin
         cur_in = rd_ff;
         j_in   = i_plus;
      end

      if (cmd.cmp) begin
         if (swap) begin
            cur_in = rd_ff;
         end
         if (status.j_more) begin
            j_in = j_plus;
         end
      end

      if (cmd.wr_i) begin
         i_in = status.i_more ? i_plus : '0;
      end

      if (cmd.sc_first) begin
         prev_in = rd_ff;
         if (status.n_one) begin
            res_in = final_val;
         end else begin
            i_in = IDX_BITS'(1);
         end
      end

      if (cmd.sc_cmp) begin
         prev_in = rd_ff;
         if (hit) begin
            res_in = lo_plus;
         end else if (!sc_more) begin
            res_in = final_val;
         end else begin
            i_in = i_plus;
         end
      end

      if (cmd.push) begin
         out_valid_in = 1'b1;
         out_miss_in  = res_ff;
         out_ovf_in   = ovf_ff;
         count_in     = '0;
         ovf_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      res_ff      <= res_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      out_miss_ff <= out_miss_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_missing    = out_miss_ff;
   assign rsp_overflowed = out_ovf_ff;

endmodule

// ===== rtl/core/sort_and_find_missing_number.sv =====
// Sequence: a set of n stored values loads at one beat per cycle; after the last beat the
// exchange sort runs in the value store (skipped for n = 1), then the scan, then the push,
// all sharing the single read and write port of the value store.
// Throughput: one beat per cycle while loading; input is stalled until the result is
// registered, and the next set may load while that result waits to be taken.
// Reset: synchronous, active high; clears the count, the overflow flag and the output valid.
module sort_and_find_missing_number import sfmn_pkg::*; (
   input logic       clock,
   input logic       reset,
   sfmn_req_if.sink   req_chan,
   sfmn_rsp_if.source rsp_chan
);

   sfmn_cmd_type    cmd;
   sfmn_status_type status;

   sfmn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sfmn_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_value      (req_chan.value),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_missing    (rsp_chan.missing),
      .rsp_overflowed (rsp_chan.overflowed)
   );

endmodule

// ===== rtl/core/sfmn_checker.sv =====
// Port-level checker for the missing-number finder, with its bind.
`include "assert_macros.svh"

module sfmn_checker import sfmn_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_last,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [MISS_BITS-1:0] rsp_missing,
   input logic                 rsp_overflowed
);

   // after reset the block takes input and shows no result
   `ASSERT_RST(a_reset_state, (reset |=> (req_ready && !rsp_valid)), "bad state after reset")

   // the final beat of a set stalls the input while the set is processed
   `ASSERT_CLK(a_last_stalls, ((req_valid && req_ready && req_last) |=> !req_ready), "no stall after last beat")

   // a new result appears only out of the push step, never while loading
   `ASSERT_CLK(a_rsp_origin, ($rose(rsp_valid) |-> $past(!req_ready)), "result without a finished set")

   // a stalled result beat holds
   `ASSERT_CLK(a_rsp_hold, ((rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_missing) && $stable(rsp_overflowed))), "result beat changed while stalled")

endmodule

bind sort_and_find_missing_number sfmn_checker u_sfmn_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_last       (req_chan.last),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_missing    (rsp_chan.missing),
   .rsp_overflowed (rsp_chan.overflowed)
);
